// ===== hw/rtl/rsac_pkg.sv =====
`default_nettype none

package rsac_pkg;

  // sprite store geometry and destination frame size
  localparam int SPRITE_MAX_W = 64;
  localparam int SPRITE_MAX_H = 256;
  localparam int FRAME_DIM    = 512;

  localparam int COL_W       = $clog2(SPRITE_MAX_W);
  localparam int ROW_W       = $clog2(SPRITE_MAX_H);
  localparam int ADDR_W      = COL_W + ROW_W;
  localparam int STORE_DEPTH = SPRITE_MAX_W * SPRITE_MAX_H;

  // q2.14 fixed point
  localparam int Q14_FRAC = 14;
  localparam int Q14_HALF = 8192;

  localparam logic [7:0] FULL_ALPHA = 8'hFF;

  // item kinds
  localparam logic KIND_LOAD      = 1'b0;
  localparam logic KIND_COMPOSITE = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_COSINE        = 3'd0;
  localparam logic [2:0] REG_SINE          = 3'd1;
  localparam logic [2:0] REG_CENTRE_X      = 3'd2;
  localparam logic [2:0] REG_CENTRE_Y      = 3'd3;
  localparam logic [2:0] REG_PIVOT_COL     = 3'd4;
  localparam logic [2:0] REG_PIVOT_ROW     = 3'd5;
  localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd6;
  localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd7;

  // per-stage control that travels with each item
  typedef struct packed {
    logic valid;
    logic load;
    logic live;
  } tag_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rotated_sprite_alpha_compositor_top.sv =====
`default_nettype none

// rotated sprite compositor: blends a rotated argb sprite over a raster stream
// input channel (in_valid / in_ready): one item per transfer; kind selects a
//   sprite load (sprite_address, sprite_argb) or a composite of one destination
//   pixel (dest_x, dest_y, background_rgb)
// output channel (out_valid / out_ready): exactly one result per input item, in
//   order; write_enable says whether pixel_out replaces the background, loads
//   always give pixel_out 0 and write_enable 0
// configuration: cfg_we writes cfg_data to register cfg_index at once; only
//   write while the pipeline is empty
// throughput: one item per cycle while the output is not stalled, set by the seven-stage
//   pipeline and the sprite store, written by a load or read by a composite at one address
// stalls: the whole pipeline holds while a result waits on out_ready; in_ready
//   follows that hold, so nothing is dropped or repeated
// reset: clears all stage valid bits and loads the default rotation setup; the
//   sprite store is not cleared and must be loaded before it is sampled

module rotated_sprite_alpha_compositor_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [13:0] sprite_address,
  input  wire logic [31:0] sprite_argb,
  input  wire logic [8:0]  dest_x,
  input  wire logic [8:0]  dest_y,
  input  wire logic [23:0] background_rgb,
  // output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      pixel_out,
  output logic             write_enable
);

  localparam int AW = rsac_pkg::ADDR_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic signed [15:0] cosine_q14;
  logic signed [15:0] sine_q14;
  logic [8:0]         centre_x;
  logic [8:0]         centre_y;
  logic [5:0]         pivot_col;
  logic [7:0]         pivot_row;
  logic [6:0]         sprite_width;
  logic [8:0]         sprite_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      cosine_q14    <= 16'sd16384;
      sine_q14      <= 16'sd0;
      centre_x      <= 9'd240;
      centre_y      <= 9'd240;
      pivot_col     <= 6'd32;
      pivot_row     <= 8'd50;
      sprite_width  <= 7'd63;
      sprite_height <= 9'd240;
    end else if (cfg_we) begin
      case (cfg_index)
        rsac_pkg::REG_COSINE:        cosine_q14    <= $signed(cfg_data);
        rsac_pkg::REG_SINE:          sine_q14      <= $signed(cfg_data);
        rsac_pkg::REG_CENTRE_X:      centre_x      <= cfg_data[8:0];
        rsac_pkg::REG_CENTRE_Y:      centre_y      <= cfg_data[8:0];
        rsac_pkg::REG_PIVOT_COL:     pivot_col     <= cfg_data[5:0];
        rsac_pkg::REG_PIVOT_ROW:     pivot_row     <= cfg_data[7:0];
        rsac_pkg::REG_SPRITE_WIDTH:  sprite_width  <= cfg_data[6:0];
        rsac_pkg::REG_SPRITE_HEIGHT: sprite_height <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline advance: every stage moves together unless the output is stalled
  // ---------------------------------------------------------------------------
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  rsac_pkg::tag_t s1_tag, s2_tag, s3_tag, s4_tag, s5_tag, s6_tag, s7_tag;
  rsac_pkg::tag_t s1_tag_next, s5_tag_next, s6_tag_next;

  // ---------------------------------------------------------------------------
  // stage 1: offsets from the rotation centre, frame check
  // ---------------------------------------------------------------------------
  logic signed [9:0] s1_fx, s1_fy, s1_fx_next, s1_fy_next;
  logic [AW-1:0]     s1_addr, s2_addr, s3_addr, s4_addr;
  logic [31:0]       s1_argb, s2_argb, s3_argb, s4_argb;
  logic [23:0]       s1_bg, s2_bg, s3_bg, s4_bg, s5_bg, s6_bg;
  logic              in_frame;

  assign in_frame   = (32'(dest_x) < rsac_pkg::FRAME_DIM) &&
                      (32'(dest_y) < rsac_pkg::FRAME_DIM);
  assign s1_fx_next = $signed({1'b0, dest_x}) - $signed({1'b0, centre_x});
  assign s1_fy_next = $signed({1'b0, dest_y}) - $signed({1'b0, centre_y});

  always_comb begin
    s1_tag_next.valid = in_valid;
    s1_tag_next.load  = (kind == rsac_pkg::KIND_LOAD);
    // loads stay live only when the address falls inside the store
    s1_tag_next.live  = (kind == rsac_pkg::KIND_LOAD) ?
                        (32'(sprite_address) < rsac_pkg::STORE_DEPTH) : in_frame;
  end

  // ---------------------------------------------------------------------------
  // stage 2: the four rotation products
  // ---------------------------------------------------------------------------
  logic signed [25:0] s2_xc, s2_ys, s2_xs, s2_yc;

  // ---------------------------------------------------------------------------
  // stage 3: u and v in q2.14 with one half added
  // ---------------------------------------------------------------------------
  logic signed [26:0] s3_u, s3_v, s3_u_next, s3_v_next;

  assign s3_u_next = $signed({s2_xc[25], s2_xc}) + $signed({s2_ys[25], s2_ys}) +
                     27'(rsac_pkg::Q14_HALF);
  assign s3_v_next = $signed({s2_yc[25], s2_yc}) - $signed({s2_xs[25], s2_xs}) +
                     27'(rsac_pkg::Q14_HALF);

  // ---------------------------------------------------------------------------
  // stage 4: divide by one in q14, rounding toward zero
  // ---------------------------------------------------------------------------
  localparam int QW = 27 - rsac_pkg::Q14_FRAC;

  logic signed [26:0]   u_adj, v_adj;
  logic signed [QW-1:0] s4_qu, s4_qv;

  // negative values get the fraction mask added before the shift
  assign u_adj = s3_u + $signed({{QW{1'b0}}, {rsac_pkg::Q14_FRAC{s3_u[26]}}});
  assign v_adj = s3_v + $signed({{QW{1'b0}}, {rsac_pkg::Q14_FRAC{s3_v[26]}}});

  // ---------------------------------------------------------------------------
  // stage 5: sprite coordinates, clip against the sprite size, store address
  // ---------------------------------------------------------------------------
  logic signed [QW:0] sx, sy;
  logic [6:0]         w_sat;
  logic [8:0]         h_sat;
  logic               src_inside;
  logic [AW-1:0]      s5_addr, s5_addr_next;
  logic [31:0]        s5_argb;

  assign w_sat = (32'(sprite_width) > rsac_pkg::SPRITE_MAX_W) ?
                 7'(rsac_pkg::SPRITE_MAX_W) : sprite_width;
  assign h_sat = (32'(sprite_height) > rsac_pkg::SPRITE_MAX_H) ?
                 9'(rsac_pkg::SPRITE_MAX_H) : sprite_height;

  assign sx = $signed((QW + 1)'(pivot_col)) + $signed({s4_qu[QW-1], s4_qu});
  assign sy = $signed((QW + 1)'(pivot_row)) + $signed({s4_qv[QW-1], s4_qv});

  assign src_inside = !sx[QW] && !sy[QW] &&
                      (sx < $signed((QW + 1)'(w_sat))) &&
                      (sy < $signed((QW + 1)'(h_sat)));

  always_comb begin
    s5_tag_next      = s4_tag;
    s5_tag_next.live = s4_tag.live && (s4_tag.load || src_inside);
    s5_addr_next     = s4_tag.load ? s4_addr :
                       {sy[rsac_pkg::ROW_W-1:0], sx[rsac_pkg::COL_W-1:0]};
  end

  // ---------------------------------------------------------------------------
  // sprite store: loads write and composites read, both from stage 5
  // ---------------------------------------------------------------------------
  logic        ram_we, ram_re;
  logic [31:0] ram_rdata;

  assign ram_we = adv && s5_tag.valid && s5_tag.load && s5_tag.live;
  assign ram_re = adv && s5_tag.valid && !s5_tag.load && s5_tag.live;

  rsac_ram #(
    .WIDTH (32),
    .DEPTH (rsac_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s5_addr),
    .wdata (s5_argb),
    .re    (ram_re),
    .raddr (s5_addr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // stage 6: alpha decode and per-channel weighted sums
  // ---------------------------------------------------------------------------
  logic [7:0]  sp_a, inv_a;
  logic [15:0] mix_r, mix_g, mix_b;
  logic [15:0] s7_r, s7_g, s7_b;
  logic        s7_opaque;
  logic [31:0] s7_sp;

  assign sp_a  = ram_rdata[31:24];
  assign inv_a = rsac_pkg::FULL_ALPHA - sp_a;

  assign mix_r = 16'(ram_rdata[23:16]) * 16'(sp_a) + 16'(s6_bg[23:16]) * 16'(inv_a);
  assign mix_g = 16'(ram_rdata[15:8])  * 16'(sp_a) + 16'(s6_bg[15:8])  * 16'(inv_a);
  assign mix_b = 16'(ram_rdata[7:0])   * 16'(sp_a) + 16'(s6_bg[7:0])   * 16'(inv_a);

  always_comb begin
    s6_tag_next      = s6_tag;
    // transparent sprite pixels leave the background alone
    s6_tag_next.live = s6_tag.live && !s6_tag.load && (sp_a != 8'd0);
  end

  // ---------------------------------------------------------------------------
  // stage 7: divide by 255 and build the result
  // ---------------------------------------------------------------------------
  logic [16:0] q_r, q_g, q_b;
  logic [31:0] blended;

  // exact for every sum the blend can give (at most 255 * 255): x / 255 == (x + 1 + (x >> 8)) >> 8
  assign q_r = 17'(s7_r) + 17'd1 + 17'(s7_r[15:8]);
  assign q_g = 17'(s7_g) + 17'd1 + 17'(s7_g[15:8]);
  assign q_b = 17'(s7_b) + 17'd1 + 17'(s7_b[15:8]);

  assign blended = {rsac_pkg::FULL_ALPHA, q_r[15:8], q_g[15:8], q_b[15:8]};

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag    <= '0;
      s2_tag    <= '0;
      s3_tag    <= '0;
      s4_tag    <= '0;
      s5_tag    <= '0;
      s6_tag    <= '0;
      s7_tag    <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_tag    <= s1_tag_next;
      s2_tag    <= s1_tag;
      s3_tag    <= s2_tag;
      s4_tag    <= s3_tag;
      s5_tag    <= s5_tag_next;
      s6_tag    <= s5_tag;
      s7_tag    <= s6_tag_next;
      out_valid <= s7_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_fx   <= s1_fx_next;
      s1_fy   <= s1_fy_next;
      s1_addr <= sprite_address[AW-1:0];
      s1_argb <= sprite_argb;
      s1_bg   <= background_rgb;

      s2_xc   <= 26'(s1_fx) * 26'(cosine_q14);
      s2_ys   <= 26'(s1_fy) * 26'(sine_q14);
      s2_xs   <= 26'(s1_fx) * 26'(sine_q14);
      s2_yc   <= 26'(s1_fy) * 26'(cosine_q14);
      s2_addr <= s1_addr;
      s2_argb <= s1_argb;
      s2_bg   <= s1_bg;

      s3_u    <= s3_u_next;
      s3_v    <= s3_v_next;
      s3_addr <= s2_addr;
      s3_argb <= s2_argb;
      s3_bg   <= s2_bg;

      s4_qu   <= u_adj[26:rsac_pkg::Q14_FRAC];
      s4_qv   <= v_adj[26:rsac_pkg::Q14_FRAC];
      s4_addr <= s3_addr;
      s4_argb <= s3_argb;
      s4_bg   <= s3_bg;

      s5_addr <= s5_addr_next;
      s5_argb <= s4_argb;
      s5_bg   <= s4_bg;

      s6_bg   <= s5_bg;

      s7_r      <= mix_r;
      s7_g      <= mix_g;
      s7_b      <= mix_b;
      s7_opaque <= (sp_a == rsac_pkg::FULL_ALPHA);
      s7_sp     <= ram_rdata;

      write_enable <= s7_tag.live;
      pixel_out    <= !s7_tag.live ? 32'd0 : (s7_opaque ? s7_sp : blended);
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // the sprite store is either written by a load or read by a composite, never both
  a_port_exclusive : assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("sprite store written and read in one cycle");

  // a held result must freeze the store so nothing is written twice or lost
  a_stall_freezes_store : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> (!ram_we && !ram_re))
    else $error("sprite store accessed while output stalled");

  // every written pixel is opaque
  a_written_opaque : assert property (@(posedge clk) disable iff (rst)
    (out_valid && write_enable) |-> (pixel_out[31:24] == rsac_pkg::FULL_ALPHA))
    else $error("written pixel is not opaque");

  // a result that does not write carries a zero pixel
  a_nowrite_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_enable) |-> (pixel_out == 32'd0))
    else $error("non-written result carries a pixel");

  // reset empties the pipeline
  a_reset_empty : assert property (@(posedge clk)
    rst |=> (!out_valid && !s5_tag.valid))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ===== hw/rtl/rsac_ram.sv =====
`default_nettype none

module rsac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== test/rotated_sprite_alpha_compositor_top_tb.sv =====
module rotated_sprite_alpha_compositor_top_tb;

  // one pending input transfer; pause marks a point where the sender holds off
  // until every outstanding result has come back
  typedef struct packed {
    logic        pause;
    logic        kind;
    logic [13:0] addr;
    logic [31:0] argb;
    logic [8:0]  dx;
    logic [8:0]  dy;
    logic [23:0] bg;
  } pix_item_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        we;
  } pix_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = rsac_pkg::REG_COSINE;
  logic [15:0] cfg_data = 16'h0000;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = rsac_pkg::KIND_LOAD;
  logic [13:0] sprite_address = 14'h0000;
  logic [31:0] sprite_argb = 32'h0000_0000;
  logic [8:0]  dest_x = 9'h000;
  logic [8:0]  dest_y = 9'h000;
  logic [23:0] background_rgb = 24'h00_0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] pixel_out;
  logic        write_enable;

  rotated_sprite_alpha_compositor_top u_dut (.*);

  always #2 clk = ~clk;

  // local copy of the rotation setup, as last written
  int cos_q = 16384;
  int sin_q = 0;
  int cx    = 240;
  int cy    = 240;
  int pcol  = 32;
  int prow  = 50;
  int spr_w = 63;
  int spr_h = 240;
  bit cfg_junk = 1'b0;

  // sprite contents as the block should hold them, and which entries the
  // generator has already queued a load for
  logic [31:0] sprite_mirror [rsac_pkg::STORE_DEPTH];
  bit          gen_loaded    [rsac_pkg::STORE_DEPTH];

  pix_item_t   pixel_jobs[$];
  pix_result_t expected_pixels[$];

  int presented    = 0;
  int results_seen = 0;
  int fault_count  = 0;
  int gen_pushed   = 0;
  int n_setups     = 1;
  int n_loads      = 0;
  int n_copies     = 0;
  int n_blends     = 0;
  int n_misses     = 0;

  int          tx_wait = 0;
  int          rx_wait = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  pix_item_t   cur;
  pix_result_t want;

  function automatic void log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endfunction

  // per-item wait, with the odd stretch where a side never idles
  function automatic int pick_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 13));
  endfunction

  function automatic int used_cols();
    return (spr_w > rsac_pkg::SPRITE_MAX_W) ? rsac_pkg::SPRITE_MAX_W : spr_w;
  endfunction

  function automatic int used_rows();
    return (spr_h > rsac_pkg::SPRITE_MAX_H) ? rsac_pkg::SPRITE_MAX_H : spr_h;
  endfunction

  function automatic logic [13:0] sprite_addr(input int row, input int col);
    return 14'(row * rsac_pkg::SPRITE_MAX_W + col);
  endfunction

  function automatic logic [8:0] clamp9(input int v);
    if (v < 0) return 9'd0;
    if (v > rsac_pkg::FRAME_DIM - 1) return 9'(rsac_pkg::FRAME_DIM - 1);
    return 9'(v);
  endfunction

  // inverse rotation of a destination pixel into the sprite, q2.14 with
  // one half added and truncation toward zero
  function automatic bit locate_source(input logic [8:0] dx, input logic [8:0] dy,
                                       output int src);
    int fx, fy, u, v, sx, sy;
    src = 0;
    fx  = int'(dx) - cx;
    fy  = int'(dy) - cy;
    u   = fx * cos_q + fy * sin_q + rsac_pkg::Q14_HALF;
    v   = -fx * sin_q + fy * cos_q + rsac_pkg::Q14_HALF;
    sx  = pcol + u / (1 << rsac_pkg::Q14_FRAC);
    sy  = prow + v / (1 << rsac_pkg::Q14_FRAC);
    if (sx < 0 || sx >= used_cols() || sy < 0 || sy >= used_rows()) return 1'b0;
    src = sy * rsac_pkg::SPRITE_MAX_W + sx;
    return 1'b1;
  endfunction

  function automatic logic [7:0] mix_chan(input int s, input int b, input int a);
    return 8'((s * a + b * (int'(rsac_pkg::FULL_ALPHA) - a)) /
              int'(rsac_pkg::FULL_ALPHA));
  endfunction

  // expected result of one item; loads update the sprite copy
  function automatic pix_result_t next_dest_pixel(input pix_item_t it);
    pix_result_t res;
    int          src;
    logic [31:0] sp;
    res = '0;
    if (it.kind == rsac_pkg::KIND_LOAD) begin
      sprite_mirror[it.addr] = it.argb;
      n_loads++;
      return res;
    end
    if (!locate_source(it.dx, it.dy, src)) begin
      n_misses++;
      return res;
    end
    sp = sprite_mirror[src];
    if (sp[31:24] == 8'h00) begin
      n_misses++;
      return res;
    end
    res.we = 1'b1;
    if (sp[31:24] == rsac_pkg::FULL_ALPHA) begin
      res.pixel = sp;
      n_copies++;
    end else begin
      res.pixel = {rsac_pkg::FULL_ALPHA,
                   mix_chan(sp[23:16], it.bg[23:16], sp[31:24]),
                   mix_chan(sp[15:8],  it.bg[15:8],  sp[31:24]),
                   mix_chan(sp[7:0],   it.bg[7:0],   sp[31:24])};
      n_blends++;
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_argb();
    logic [7:0] a;
    case ($urandom_range(0, 5))
      0:       a = 8'h00;
      1, 2:    a = rsac_pkg::FULL_ALPHA;
      3:       a = 8'($urandom_range(1, 2));
      4:       a = 8'($urandom_range(253, 254));
      default: a = 8'($urandom);
    endcase
    return {a, 24'($urandom)};
  endfunction

  function automatic void push_load(input logic [13:0] a, input logic [31:0] px);
    pix_item_t it;
    it.pause = 1'b0;
    it.kind  = rsac_pkg::KIND_LOAD;
    it.addr  = a;
    it.argb  = px;
    it.dx    = 9'($urandom);
    it.dy    = 9'($urandom);
    it.bg    = 24'($urandom);
    gen_loaded[a] = 1'b1;
    pixel_jobs.push_back(it);
    gen_pushed++;
  endfunction

  // a composite that would sample an entry never loaded gets a load first
  function automatic void push_composite(input logic [8:0] x, input logic [8:0] y,
                                         input logic [23:0] bgc);
    pix_item_t it;
    int        src;
    if (locate_source(x, y, src) && !gen_loaded[src]) push_load(14'(src), rand_argb());
    it.pause = 1'b0;
    it.kind  = rsac_pkg::KIND_COMPOSITE;
    it.addr  = 14'($urandom);
    it.argb  = $urandom;
    it.dx    = x;
    it.dy    = y;
    it.bg    = bgc;
    pixel_jobs.push_back(it);
    gen_pushed++;
  endfunction

  function automatic void push_pause();
    pix_item_t it;
    it       = '0;
    it.pause = 1'b1;
    pixel_jobs.push_back(it);
  endfunction

  // register write; narrow registers may carry junk in the unused bits
  task automatic write_reg(input logic [2:0] idx, input int value, input int bits);
    logic [15:0] mask;
    logic [15:0] data;
    mask = 16'((32'h1 << bits) - 1);
    data = (16'(value) & mask) | (cfg_junk ? (16'($urandom) & ~mask) : 16'h0000);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      rsac_pkg::REG_COSINE:        cos_q = $signed(data);
      rsac_pkg::REG_SINE:          sin_q = $signed(data);
      rsac_pkg::REG_CENTRE_X:      cx    = data[8:0];
      rsac_pkg::REG_CENTRE_Y:      cy    = data[8:0];
      rsac_pkg::REG_PIVOT_COL:     pcol  = data[5:0];
      rsac_pkg::REG_PIVOT_ROW:     prow  = data[7:0];
      rsac_pkg::REG_SPRITE_WIDTH:  spr_w = data[6:0];
      rsac_pkg::REG_SPRITE_HEIGHT: spr_h = data[8:0];
      default: ;
    endcase
  endtask

  task automatic apply_setup(input int c, input int s, input int x, input int y,
                             input int pc, input int pr, input int w, input int h);
    write_reg(rsac_pkg::REG_COSINE,        c,  16);
    write_reg(rsac_pkg::REG_SINE,          s,  16);
    write_reg(rsac_pkg::REG_CENTRE_X,      x,  9);
    write_reg(rsac_pkg::REG_CENTRE_Y,      y,  9);
    write_reg(rsac_pkg::REG_PIVOT_COL,     pc, 6);
    write_reg(rsac_pkg::REG_PIVOT_ROW,     pr, 8);
    write_reg(rsac_pkg::REG_SPRITE_WIDTH,  w,  7);
    write_reg(rsac_pkg::REG_SPRITE_HEIGHT, h,  9);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_setups++;
  endtask

  // mostly loads into the sprite in use and composites around the centre,
  // with a share of loads and composites anywhere and the odd pause
  task automatic random_burst(input int n);
    int start, span, w, h, k;
    @(negedge clk);
    start = gen_pushed;
    w     = used_cols();
    h     = used_rows();
    span  = w + h + 4;
    while (gen_pushed - start < n) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          k = $urandom_range(1, 8);
          repeat (k) begin
            if (w > 0 && h > 0)
              push_load(sprite_addr($urandom_range(0, h - 1), $urandom_range(0, w - 1)),
                        rand_argb());
            else
              push_load(14'($urandom), rand_argb());
          end
        end
        3: push_load(14'($urandom), rand_argb());
        4: push_composite(9'($urandom), 9'($urandom), 24'($urandom));
        5: begin
          if ($urandom_range(0, 15) == 0) push_pause();
          push_composite(9'($urandom), 9'($urandom), 24'($urandom));
        end
        default:
          push_composite(clamp9(cx + int'($urandom_range(0, 2 * span)) - span),
                         clamp9(cy + int'($urandom_range(0, 2 * span)) - span),
                         24'($urandom));
      endcase
    end
  endtask

  // wait until the queue is empty and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_jobs.size() != 0 || in_valid || results_seen < presented);
  endtask

  // sender: presents queued items, draws a gap after each transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && in_ready) tx_wait = pick_wait(tx_calm);
      if (!in_valid || in_ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (pixel_jobs.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pixel_jobs[0].pause) begin
          // hold off until the pipeline has emptied
          if (results_seen >= presented) void'(pixel_jobs.pop_front());
          in_valid <= 1'b0;
        end else begin
          cur = pixel_jobs.pop_front();
          kind           <= cur.kind;
          sprite_address <= cur.addr;
          sprite_argb    <= cur.argb;
          dest_x         <= cur.dx;
          dest_y         <= cur.dy;
          background_rgb <= cur.bg;
          in_valid       <= 1'b1;
          // items go through in order, so predicting now matches transfer order
          expected_pixels.push_back(next_dest_pixel(cur));
          presented++;
        end
      end
    end
  end

  // receiver: checks each result against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          log_fault($sformatf("result %0d: no result expected, got pixel_out %h we %b",
                              results_seen, pixel_out, write_enable));
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_out !== want.pixel)
            log_fault($sformatf("result %0d: pixel_out expected %h got %h",
                                results_seen, want.pixel, pixel_out));
          if (write_enable !== want.we)
            log_fault($sformatf("result %0d: write_enable expected %b got %b",
                                results_seen, want.we, write_enable));
        end
        results_seen <= results_seen + 1;
        rx_wait = pick_wait(rx_calm);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed, on the reset setup (identity rotation, centre 240,240 on 32,50)
    @(negedge clk);
    push_load(sprite_addr(50, 32), 32'hFF12_3456);   // opaque
    push_load(sprite_addr(50, 33), 32'h00AB_CDEF);   // fully transparent
    push_load(sprite_addr(50, 34), 32'h80FF_0000);   // half alpha
    push_load(sprite_addr(50, 31), 32'h01FF_FFFF);   // lowest nonzero alpha
    push_load(sprite_addr(50, 30), 32'hFE00_FF00);   // highest blending alpha
    push_load(sprite_addr(239, 62), 32'hFFFF_FFFF);  // last column and row in use
    push_load(sprite_addr(0, 0), 32'h7F00_0000);
    push_load(14'h3FFF, 32'h0000_0000);              // top of store, outside sprite
    push_composite(9'd240, 9'd240, 24'h00_0000);     // centre, straight copy
    push_composite(9'd241, 9'd240, 24'hFF_FFFF);     // alpha 0, nothing written
    push_composite(9'd242, 9'd240, 24'h00_0000);     // blend on black
    push_composite(9'd242, 9'd240, 24'hFF_FFFF);     // blend on white
    push_composite(9'd239, 9'd240, 24'h12_3456);     // -0.5 truncates onto column 32
    push_composite(9'd238, 9'd240, 24'hFF_FFFF);
    push_composite(9'd237, 9'd240, 24'h00_0000);
    push_composite(9'd270, 9'd429, 24'h55_AA55);     // far corner of sprite
    push_composite(9'd271, 9'd429, 24'h55_AA55);     // one past width
    push_composite(9'd270, 9'd430, 24'h55_AA55);     // one past height
    push_composite(9'd207, 9'd189, 24'hAB_CDEF);     // lands on 0,0
    push_composite(9'd206, 9'd188, 24'hAB_CDEF);     // just before 0,0
    push_composite(9'd0, 9'd0, 24'hFF_FFFF);
    push_composite(9'd511, 9'd511, 24'h00_0000);
    push_pause();
    random_burst(200);
    wait_drained();

    // quarter turn, full sprite size
    apply_setup(0, 16384, 100, 400, 10, 200, 64, 256);
    random_burst(130);
    wait_drained();

    // register extremes: the ends of the q2.14 range, sizes past the maximum
    apply_setup(-32768, 32767, 511, 0, 63, 255, 127, 511);
    random_burst(120);
    wait_drained();

    // half turn on a single-pixel sprite at the frame corner
    apply_setup(-16384, 0, 0, 511, 0, 0, 1, 1);
    random_burst(60);
    wait_drained();

    // zero width, then zero height: every source lies outside
    apply_setup(16384, 0, 240, 240, 32, 50, 0, 256);
    random_burst(25);
    wait_drained();
    apply_setup(11585, 11585, 300, 200, 4, 4, 8, 0);
    random_burst(25);
    wait_drained();

    // eighth turn the other way, small sprite
    apply_setup(11585, -11585, 256, 256, 4, 4, 8, 8);
    random_burst(120);
    wait_drained();

    // random setups, junk in the unused register bits
    cfg_junk = 1'b1;
    repeat (3) begin
      apply_setup(int'($urandom_range(0, 32768)) - 16384,
                  int'($urandom_range(0, 32768)) - 16384,
                  int'($urandom_range(0, 511)), int'($urandom_range(0, 511)),
                  int'($urandom_range(0, 63)), int'($urandom_range(0, 255)),
                  int'($urandom_range(1, 64)), int'($urandom_range(1, 256)));
      random_burst(150);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (expected_pixels.size() != 0)
      log_fault($sformatf("%0d expected results never arrived", expected_pixels.size()));

    $display("run covered %0d rotation setups, %0d transfers in, %0d sprite loads",
             n_setups, presented, n_loads);
    $display("composites gave %0d opaque copies, %0d blends, %0d left untouched; %0d faults",
             n_copies, n_blends, n_misses, fault_count);
    if (fault_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, well past the slowest legal run
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
